>>> sv/bhlf_pkg.sv
// Shared types, constants and helpers for the line framer/deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package bhlf_pkg;

  localparam int HdrLen = 45;
  localparam logic [8*HdrLen-1:0] HdrText =
    "(This file must be converted with BinHex 4.0)";

  localparam int StepW = 6;
  localparam int ColW  = 7;

  localparam logic [7:0] ByteColon = 8'h3A;
  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] ByteLf    = 8'h0A;

  localparam logic [1:0] REG_DIRECTION  = 2'd0;
  localparam logic [1:0] REG_EOL_FIRST  = 2'd1;
  localparam logic [1:0] REG_EOL_SECOND = 2'd2;
  localparam logic [1:0] REG_EOL_LENGTH = 2'd3;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    JOB_HDR,
    JOB_BYTE,
    JOB_BYTE_EOL,
    JOB_FIN
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       colon_end;
  } job_t;

  typedef struct packed {
    logic [7:0] eol_first;
    logic [7:0] eol_second;
    logic [1:0] eol_length;
  } eol_cfg_t;

  function automatic logic [7:0] hdr_byte(input logic [StepW-1:0] idx);
    logic [7:0] b;
    b = 8'd0;
    if (int'(idx) < HdrLen) begin
      b = HdrText[8*(HdrLen-1-int'(idx)) +: 8];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> sv/binhex_line_framer_deframer_unit.sv
// Top level of the BinHex line framer/deframer: config registers plus
// front end, job queue and back end. Depends on bhlf_pkg and submodules.
// The first result beat passes through the job queue, then the back end's output register.
// Throughput: one input beat per cycle; a start in write mode gives 46 to 48
// output beats, a data byte at a line break or a finish 1 to 3, one per cycle unless out_stall;
// input stalls while the job queue is full. Synchronous active-low reset.
`default_nettype none

module binhex_line_framer_deframer_unit #(
  parameter int LINE_LENGTH = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_kind,
  output logic             out_last
);

  logic               direction_r;
  bhlf_pkg::eol_cfg_t eol_cfg_r;
  logic               cfg_wr, accept, push, pop, full, head_valid;
  bhlf_pkg::job_t     push_job, head_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      eol_cfg_r   <= '{eol_first: 8'd13, eol_second: 8'd10, eol_length: 2'd2};
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bhlf_pkg::REG_DIRECTION:  direction_r          <= pwdata[0];
        bhlf_pkg::REG_EOL_FIRST:  eol_cfg_r.eol_first  <= pwdata[7:0];
        bhlf_pkg::REG_EOL_SECOND: eol_cfg_r.eol_second <= pwdata[7:0];
        bhlf_pkg::REG_EOL_LENGTH: eol_cfg_r.eol_length <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bhlf_pkg::REG_DIRECTION:  prdata = {31'd0, direction_r};
      bhlf_pkg::REG_EOL_FIRST:  prdata = {24'd0, eol_cfg_r.eol_first};
      bhlf_pkg::REG_EOL_SECOND: prdata = {24'd0, eol_cfg_r.eol_second};
      bhlf_pkg::REG_EOL_LENGTH: prdata = {30'd0, eol_cfg_r.eol_length};
      default:                  prdata = '0;
    endcase
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  bhlf_front #(.LINE_LENGTH(LINE_LENGTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_operation),
    .data_byte (in_data_byte),
    .direction (direction_r),
    .push      (push),
    .job       (push_job)
  );

  bhlf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  bhlf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .eol_cfg    (eol_cfg_r),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_kind   (out_kind),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

>>> sv/bhlf_front.sv
// Front end: accepts items, tracks stream phase and column, queues jobs.
// Depends on bhlf_pkg.
`default_nettype none

module bhlf_front #(
  parameter int LINE_LENGTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [1:0]      operation,
  input  wire logic [7:0]      data_byte,
  input  wire logic            direction,
  output logic                 push,
  output bhlf_pkg::job_t       job
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_R_LINESTART,
    PH_R_SKIP,
    PH_R_DATA,
    PH_W_DATA
  } phase_t;

  localparam logic [bhlf_pkg::ColW-1:0] LineLen = bhlf_pkg::ColW'(LINE_LENGTH);

  phase_t                      phase_r, phase_nxt;
  logic [bhlf_pkg::ColW-1:0]   column_r, column_nxt;
  logic [bhlf_pkg::ColW-1:0]   col_inc;
  logic                        is_eol, is_colon;

  always_comb begin
    phase_nxt  = phase_r;
    column_nxt = column_r;
    push       = 1'b0;
    job        = '{kind: bhlf_pkg::JOB_BYTE, data: data_byte, colon_end: 1'b0};
    is_eol     = (data_byte == bhlf_pkg::ByteCr) || (data_byte == bhlf_pkg::ByteLf);
    is_colon   = (data_byte == bhlf_pkg::ByteColon);
    col_inc    = column_r + bhlf_pkg::ColW'(1);
    if (accept) begin
      case (bhlf_pkg::op_t'(operation))
        bhlf_pkg::OP_START: begin
          if (direction) begin
            push       = 1'b1;
            job.kind   = bhlf_pkg::JOB_HDR;
            phase_nxt  = PH_W_DATA;
            column_nxt = bhlf_pkg::ColW'(1);
          end else begin
            phase_nxt  = PH_R_LINESTART;
            column_nxt = '0;
          end
        end
        bhlf_pkg::OP_DATA: begin
          case (phase_r)
            PH_R_LINESTART: begin
              if (is_colon) begin
                phase_nxt  = PH_R_DATA;
                column_nxt = bhlf_pkg::ColW'(1);
              end else if (!is_eol) begin
                phase_nxt = PH_R_SKIP;
              end
            end
            PH_R_SKIP: begin
              if (is_eol) phase_nxt = PH_R_LINESTART;
            end
            PH_R_DATA: begin
              if (is_colon) begin
                push          = 1'b1;
                job.colon_end = 1'b1;
                phase_nxt     = PH_IDLE;
                column_nxt    = '0;
              end else if (!is_eol) begin
                push = 1'b1;
              end
            end
            PH_W_DATA: begin
              push = 1'b1;
              if (col_inc >= LineLen) begin
                job.kind   = bhlf_pkg::JOB_BYTE_EOL;
                column_nxt = '0;
              end else begin
                column_nxt = col_inc;
              end
            end
            default: ;
          endcase
        end
        bhlf_pkg::OP_FINISH: begin
          if (phase_r == PH_W_DATA) begin
            push     = 1'b1;
            job.kind = bhlf_pkg::JOB_FIN;
            job.data = bhlf_pkg::ByteColon;
          end
          phase_nxt  = PH_IDLE;
          column_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      column_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      column_r <= column_nxt;
    end
  end

  a_wcol_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_W_DATA |-> column_r < LineLen)
    else $error("write column reached line length");

  a_rcol_small: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_W_DATA) |-> column_r <= bhlf_pkg::ColW'(1))
    else $error("column advanced outside write mode");

  a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && phase_r == PH_IDLE) |-> job.kind == bhlf_pkg::JOB_HDR)
    else $error("job queued with no open stream");

endmodule

`default_nettype wire

>>> sv/bhlf_queue.sv
// Short job queue between front and back ends.
// Depends on bhlf_pkg for the job type.
`default_nettype none

module bhlf_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bhlf_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                head_valid,
  output bhlf_pkg::job_t      head_job
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  bhlf_pkg::job_t       mem_r [DEPTH];
  logic [PtrW-1:0]      wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]      count_r, count_nxt;

  assign full       = (count_r == CntW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) count_nxt = count_r + CntW'(1);
    else if (!push && pop) count_nxt = count_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> sv/bhlf_back.sv
// Back end: expands queued jobs into output beats, one per cycle unless out_stall holds them.
// Depends on bhlf_pkg (header text, job and config types).
`default_nettype none

module bhlf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire bhlf_pkg::job_t    head_job,
  input  wire bhlf_pkg::eol_cfg_t eol_cfg,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_kind,
  output logic                   out_last
);

  localparam int SW = bhlf_pkg::StepW;

  logic [SW-1:0] step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic          out_last_r, out_last_nxt;

  logic [1:0]    eol_len;
  logic          is_hdr, has_eol, adv, last;
  logic [SW-1:0] pre, eol_n, total, eol_end;

  always_comb begin
    eol_len = (eol_cfg.eol_length == 2'd3) ? 2'd2 : eol_cfg.eol_length;
    is_hdr  = (head_job.kind == bhlf_pkg::JOB_HDR);
    has_eol = (head_job.kind != bhlf_pkg::JOB_BYTE);
    pre     = is_hdr ? SW'(bhlf_pkg::HdrLen) : SW'(1);
    eol_n   = has_eol ? SW'(eol_len) : '0;
    eol_end = pre + eol_n;
    total   = eol_end + (is_hdr ? SW'(1) : SW'(0));
    last    = (step_r == total - SW'(1));
    adv     = head_valid && (!out_valid_r || !out_stall);
    pop     = adv && last;

    out_byte_nxt  = out_byte_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    step_nxt      = step_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = last;
      out_kind_nxt  = 1'b0;
      step_nxt      = last ? '0 : step_r + SW'(1);
      if (step_r < pre) begin
        out_byte_nxt = is_hdr ? bhlf_pkg::hdr_byte(step_r) : head_job.data;
        out_kind_nxt = !is_hdr && head_job.colon_end;
      end else if (step_r < eol_end) begin
        out_byte_nxt = (step_r == pre) ? eol_cfg.eol_first : eol_cfg.eol_second;
      end else begin
        out_byte_nxt = bhlf_pkg::ByteColon;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < SW'(48))
    else $error("expansion step out of range");

  a_step_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != '0) |-> head_valid)
    else $error("mid-job step with empty queue");

  a_kind_is_colon: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r) |-> (out_byte_r == bhlf_pkg::ByteColon && out_last_r))
    else $error("end marker beat is not a lone colon");

endmodule

`default_nettype wire
